### hw/rtl/assert_macros.svh
// assertion macros used by the checker file bod_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define BOD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bod assertion failed");

// clocked property that is also checked during reset
`define BOD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("bod assertion failed");

`endif

### hw/rtl/bod_pkg.sv
// package of the byte offset pixel decoder: widths, codes, queue item type
// no dependencies
package bod_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 28;
  localparam int unsigned BYTE_WIDTH  = 8;
  localparam int unsigned FIFO_DEPTH  = 2;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned APB_AW      = 3;

  localparam logic [BYTE_WIDTH-1:0] START_MARK = 8'hD5;
  localparam logic [BYTE_WIDTH-1:0] ESC_BYTE   = 8'h80;
  localparam logic [15:0]           ESC_SHORT  = 16'h8000;

  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_BYTE,
    PH_SHORT,
    PH_WORD,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] delta;
    logic                   last;
  } delta_t;

endpackage

### hw/rtl/bod_front.sv
// front end: finds the start marker, classifies and gathers deltas, counts pixels
// depends on bod_pkg
module bod_front import bod_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [BYTE_WIDTH-1:0]  data_byte_i,
  input  logic [COUNT_WIDTH-1:0] element_count_i,
  output logic                   push_o,
  output delta_t                 item_o
);

  phase_e                 state_q, state_d;
  logic [1:0]             idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] gath_q, gath_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   stop;
  logic                   emit;
  logic                   last;
  logic [15:0]            short_w;
  logic [VALUE_WIDTH-1:0] delta;

  assign stop    = (state_q == PH_DONE) || (cnt_q >= element_count_i);
  assign short_w = {data_byte_i, gath_q[7:0]};

  // delta decode and datapath updates
  always_comb begin
    emit   = 1'b0;
    delta  = '0;
    idx_d  = idx_q;
    gath_d = gath_q;
    cnt_d  = cnt_q;
    if (accept_i && !stop) begin
      case (state_q)
        PH_BYTE: begin
          if (data_byte_i != ESC_BYTE) begin
            emit  = 1'b1;
            delta = {{(VALUE_WIDTH-BYTE_WIDTH){data_byte_i[7]}}, data_byte_i};
          end else begin
            idx_d  = '0;
            gath_d = '0;
          end
        end
        PH_SHORT: begin
          if (idx_q == 2'd0) begin
            gath_d[7:0] = data_byte_i;
            idx_d       = 2'd1;
          end else if (short_w != ESC_SHORT) begin
            emit  = 1'b1;
            delta = {{(VALUE_WIDTH-16){short_w[15]}}, short_w};
          end else begin
            idx_d  = '0;
            gath_d = '0;
          end
        end
        PH_WORD: begin
          if (idx_q != 2'd3) begin
            gath_d[{idx_q, 3'b000} +: 8] = data_byte_i;
            idx_d = idx_q + 2'd1;
          end else begin
            emit  = 1'b1;
            delta = {data_byte_i, gath_q[23:0]};
          end
        end
        default: begin
        end
      endcase
      if (emit) begin
        cnt_d  = cnt_q + 1'b1;
        idx_d  = '0;
        gath_d = '0;
      end
    end
  end

  assign last   = emit && (cnt_d == element_count_i);
  assign push_o = emit;
  assign item_o = '{delta: delta, last: last};

  // next phase
  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      if (stop) begin
        state_d = PH_DONE;
      end else if (emit) begin
        state_d = last ? PH_DONE : PH_BYTE;
      end else begin
        case (state_q)
          PH_WAIT:  if (data_byte_i == START_MARK) state_d = PH_BYTE;
          PH_BYTE:  state_d = PH_SHORT;
          PH_SHORT: if (idx_q != 2'd0) state_d = PH_WORD;
          default:  state_d = state_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_WAIT;
      idx_q   <= '0;
      gath_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      gath_q  <= gath_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hw/rtl/bod_fifo.sv
// short queue of decoded deltas between front and back end
// depends on bod_pkg
module bod_fifo import bod_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  delta_t item_i,
  output logic   full_o,
  input  logic   pop_i,
  output delta_t item_o,
  output logic   empty_o
);

  delta_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hw/rtl/bod_back.sv
// back end: running sum of deltas and registered pixel output
// depends on bod_pkg
module bod_back import bod_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  delta_t                 item_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [VALUE_WIDTH-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  logic [VALUE_WIDTH-1:0] sum_q, sum_d;
  logic [VALUE_WIDTH-1:0] data_q;
  logic                   last_q;
  logic                   valid_q;

  assign pop_o = !empty_i && (!valid_q || m_axis_tready);
  assign sum_d = sum_q + item_i.delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        sum_q   <= sum_d;
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= sum_d;
      last_q <= item_i.last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

### hw/rtl/byte_offset_pixel_decoder_unit.sv
// byte offset pixel decoder, top level: apb register, front end, queue, back end
// depends on bod_pkg, bod_front, bod_fifo, bod_back
//
// usage
// - s_axis carries one compressed byte per beat (tdata = data_byte)
// - m_axis carries one pixel per beat: tdata = pixel_value (32 bit signed),
//   tlast = last_pixel, high on pixel number element_count
// - apb register element_count at byte address 0, written in the access
//   cycle, pready always high, reads return the register
// - bytes before the 0xD5 start marker and after the final pixel are taken
//   and dropped; decoding stays stopped until reset
// - one byte per cycle sustained while the queue is not full; a pixel goes
//   to m_axis via the queue, written at its last byte's beat, and output register
// - the front end and back end are parted by a two entry queue; when the
//   receiver stalls the queue fills and s_axis_tready drops
// - reset clears the register, the sum, the pixel count and the queue
module byte_offset_pixel_decoder_unit import bod_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_WIDTH-1:0]  s_axis_tdata,  // [7:0] data_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [VALUE_WIDTH-1:0] m_axis_tdata,  // [31:0] pixel_value
  output logic                   m_axis_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [COUNT_WIDTH-1:0] count_q;
  logic                   accept;
  logic                   push, full, pop, empty;
  delta_t                 push_item, pop_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ELEMENT_COUNT)
                ? {{(APB_DW-COUNT_WIDTH){1'b0}}, count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ELEMENT_COUNT) begin
      count_q <= pwdata[COUNT_WIDTH-1:0];
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bod_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (s_axis_tdata),
    .element_count_i (count_q),
    .push_o          (push),
    .item_o          (push_item)
  );

  bod_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  bod_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .item_i        (pop_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### hw/rtl/bod_checker.sv
// port level checks of the byte offset pixel decoder, bound to the top level
// depends on bod_pkg, assert_macros.svh
`include "assert_macros.svh"
module bod_checker import bod_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [VALUE_WIDTH-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [APB_AW-1:0]      paddr,
  input logic [APB_DW-1:0]      pwdata,
  input logic [APB_DW-1:0]      prdata,
  input logic                   pready
);

  logic                   out_stall;
  logic                   out_last;
  logic [VALUE_WIDTH:0]   out_beat;
  logic                   cfg_sel;
  logic                   cfg_wr;
  logic [APB_DW-1:0]      wr_val;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_last  = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign out_beat  = {m_axis_tlast, m_axis_tdata};
  assign cfg_sel   = (paddr[2] == REG_ELEMENT_COUNT);
  assign cfg_wr    = psel && penable && pwrite && pready && cfg_sel;
  assign wr_val    = APB_DW'(pwdata[COUNT_WIDTH-1:0]);

  // stalled pixel beat holds
  `BOD_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_beat))
  // nothing follows the final pixel
  `BOD_ASSERT(a_quiet_after_last, out_last |=> !m_axis_tvalid)
  // register reads back what was written
  `BOD_ASSERT(a_reg_readback, cfg_wr |=> !cfg_sel || prdata == $past(wr_val))
  // byte ready is known out of reset
  `BOD_ASSERT(a_in_ready_known, !$isunknown(s_axis_tready))
  // no pixel while in reset
  `BOD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid)

endmodule

bind byte_offset_pixel_decoder_unit bod_checker u_bod_checker (.*);
